// File: src/mtt_pkg.sv
`default_nettype none
package mtt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_W = 31;
    localparam int HANDLE_W = 32;
    localparam int OWNER_W = 16;
    localparam int GEN_W = 16;
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 152;

    // input kinds
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_CANCEL = 3'd1;
    localparam logic [2:0] MODE_KILL   = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    // result kinds
    localparam logic [3:0] EV_ADDED     = 4'd0;
    localparam logic [3:0] EV_FULL      = 4'd1;
    localparam logic [3:0] EV_CANCELLED = 4'd2;
    localparam logic [3:0] EV_NOT_FOUND = 4'd3;
    localparam logic [3:0] EV_KILLED    = 4'd4;
    localparam logic [3:0] EV_FIRED_DIE = 4'd5;
    localparam logic [3:0] EV_FIRED_REP = 4'd6;
    localparam logic [3:0] EV_TICK_DONE = 4'd7;
    localparam logic [3:0] EV_INFO      = 4'd8;

    typedef struct packed {
        logic              repeat_flag;
        logic [31:0]       remaining;
        logic [TIME_W-1:0] delay;
        logic [31:0]       excess;
        logic [OWNER_W-1:0] owner;
        logic [GEN_W-1:0]  generation;
    } entry_t;

    typedef struct packed {
        logic [3:0]          code;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic [31:0]         elapsed;
        logic [4:0]          killed;
        logic [31:0]         remaining;
        logic [TIME_W-1:0]   delay;
        logic                rep;
        logic                last;
    } result_t;

endpackage
`default_nettype wire

// File: src/mtt_mod.sv
`default_nettype none
// Restoring remainder unit: one quotient bit per cycle.
// done rises after the last step and holds until the next start.
module mtt_mod
    import mtt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output logic                   done,
    output logic [TIME_W-1:0]      remainder
);
    localparam int CW = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] dvd_reg;
    logic [TIME_W-1:0] dsr_reg;
    logic [CW-1:0]     step_reg;
    logic              busy_reg;
    logic [TIME_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign remainder = rem_reg;

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done <= 1'b0;
                rem_reg <= '0;
                dvd_reg <= dividend;
                dsr_reg <= divisor;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg <= TIME_W'(trial - {1'b0, dsr_reg});
                end else begin
                    rem_reg <= trial[TIME_W-1:0];
                end
                dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == CW'(TIME_W - 1)) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: src/multi_timer_table.sv
`default_nettype none
// Timer table with generation-tagged handles.
// s_ channel: one command per transaction; s_tuser selects add, cancel,
// kill owner, query or tick. m_ channel: result transactions, m_tlast marks
// the final result of a command. Add, cancel, query and kill give one
// result; a tick gives one result per fired timer, then a done result.
// Slot state lives in a memory with a registered read; used bits in flops.
// A cancel or query with an out-of-range handle skips the slot read. Kill
// and tick walk every slot; each firing repeating timer with nonzero delay
// also runs the bit-serial remainder unit. One command is worked at a time;
// s_tready is high only between commands.
// A result waits in the output register while m_tready is low; the table
// walk stalls until it is taken, no result is dropped.
// Reset empties the table and clears the generation counter; slot
// contents are not cleared, the used bits gate every read.
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // delay_time[30:0], repeating[31], owner_id[47:32], handle[79:48],
    // tick_time[110:80]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // mode[2:0]
    input  wire logic [2:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_handle[31:0], out_owner[47:32], elapsed[79:48],
    // killed_count[84:80], remain[116:85], info_delay[147:117],
    // info_repeating[148]
    output logic [M_DATA_W-1:0]      m_tdata,
    // event_code[3:0]
    output logic [3:0]               m_tuser,
    output logic                     m_tlast
);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_KRD   = 4'd2;
    localparam logic [3:0] ST_KEV   = 4'd3;
    localparam logic [3:0] ST_TRD   = 4'd4;
    localparam logic [3:0] ST_TEV   = 4'd5;
    localparam logic [3:0] ST_TDIV  = 4'd6;
    localparam logic [3:0] ST_TNEXT = 4'd7;
    localparam logic [3:0] ST_PUSH  = 4'd8;

    entry_t mem [TIMER_SLOTS];
    entry_t rd_reg;
    logic   mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    entry_t mem_wdata;

    logic [3:0]   state_reg, ret_reg;
    logic [TIMER_SLOTS-1:0] used_reg;
    logic [GEN_W-1:0] gen_reg;
    logic         changed_reg;
    logic [IW-1:0] cnt_reg;
    logic [4:0]   kcount_reg;
    logic [2:0]   mode_reg;
    logic [TIME_W-1:0] dt_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [HANDLE_W-1:0] handle_reg;
    result_t      res_reg, out_reg;
    logic         m_valid_reg;

    // result with only kind, handle, owner and the last flag filled in
    function automatic result_t blank_result(logic [3:0] code,
                                             logic [HANDLE_W-1:0] handle,
                                             logic [OWNER_W-1:0] owner);
        result_t r;
        r = '0;
        r.code = code;
        r.handle = handle;
        r.owner = owner;
        r.last = 1'b1;
        return r;
    endfunction

    // input fields
    logic [TIME_W-1:0]   in_delay, in_tick;
    logic                in_rep;
    logic [OWNER_W-1:0]  in_owner;
    logic [HANDLE_W-1:0] in_handle;
    logic                s_acc;
    assign in_delay  = s_tdata[30:0];
    assign in_rep    = s_tdata[31];
    assign in_owner  = s_tdata[47:32];
    assign in_handle = s_tdata[79:48];
    assign in_tick   = s_tdata[110:80];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    // lowest free slot
    logic [IW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic in_range;
    assign in_range = (in_handle[15:0] < 16'(TIMER_SLOTS)) && used_reg[in_handle[IW-1:0]];

    // tick arithmetic on the entry just read
    logic [32:0]       diff;
    logic              fire;
    logic [TIME_W-1:0] over;
    logic [31:0]       el_sum, elapsed;
    logic              need_div;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_rem;
    assign diff = {1'b0, rd_reg.remaining} - {2'b0, dt_reg};
    assign fire = diff[32] || (diff == '0);
    assign over = TIME_W'(dt_reg - rd_reg.remaining[TIME_W-1:0]);
    assign el_sum = {1'b0, rd_reg.delay} + {1'b0, over};
    assign elapsed = (el_sum > rd_reg.excess) ? (el_sum - rd_reg.excess) : '0;
    assign need_div = rd_reg.repeat_flag && (rd_reg.delay != '0);

    logic cur_used;
    assign cur_used = used_reg[cnt_reg];
    assign div_start = (state_reg == ST_TEV) && cur_used && fire && need_div;

    mtt_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (over),
        .divisor   (rd_reg.delay),
        .done      (div_done),
        .remainder (div_rem)
    );

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = rd_reg;
        mem_re = 1'b0;
        mem_raddr = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                mem_raddr = in_handle[IW-1:0];
                mem_waddr = free_idx;
                mem_wdata.repeat_flag = in_rep;
                mem_wdata.remaining = {1'b0, in_delay};
                mem_wdata.delay = in_delay;
                mem_wdata.excess = '0;
                mem_wdata.owner = in_owner;
                mem_wdata.generation = gen_reg;
                if (s_acc && s_tuser == MODE_ADD && free_any) begin
                    mem_we = 1'b1;
                end
                if (s_acc && (s_tuser == MODE_CANCEL || s_tuser == MODE_QUERY) && in_range) begin
                    mem_re = 1'b1;
                end
            end
            ST_KRD, ST_TRD: mem_re = 1'b1;
            ST_TEV: begin
                if (cur_used && !fire) begin
                    mem_we = 1'b1;
                    mem_wdata.remaining = diff[31:0];
                end else if (cur_used && rd_reg.repeat_flag && !need_div) begin
                    mem_we = 1'b1;
                    mem_wdata.remaining = '0;
                    mem_wdata.excess = '0;
                end
            end
            ST_TDIV: begin
                mem_we = div_done;
                mem_wdata.remaining = {1'b0, TIME_W'(rd_reg.delay - div_rem)};
                mem_wdata.excess = {1'b0, div_rem};
            end
            default: ;
        endcase
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // command sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            gen_reg <= '0;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new result or drop the one just taken
            if (state_reg == ST_PUSH && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        mode_reg <= s_tuser;
                        dt_reg <= in_tick;
                        owner_reg <= in_owner;
                        handle_reg <= in_handle;
                        cnt_reg <= '0;
                        kcount_reg <= '0;
                        ret_reg <= ST_IDLE;
                        case (s_tuser)
                            MODE_ADD: begin
                                state_reg <= ST_PUSH;
                                if (free_any) begin
                                    used_reg[free_idx] <= 1'b1;
                                    changed_reg <= 1'b1;
                                    res_reg <= blank_result(EV_ADDED,
                                                            {gen_reg, 16'(free_idx)},
                                                            in_owner);
                                end else begin
                                    res_reg <= blank_result(EV_FULL, '1, in_owner);
                                end
                            end
                            MODE_CANCEL, MODE_QUERY: begin
                                res_reg <= blank_result(EV_NOT_FOUND, in_handle, '0);
                                state_reg <= in_range ? ST_CHK : ST_PUSH;
                            end
                            MODE_KILL: begin
                                res_reg <= blank_result(EV_KILLED, '1, in_owner);
                                state_reg <= ST_KRD;
                            end
                            MODE_TICK: begin
                                res_reg <= blank_result(EV_TICK_DONE, '1, '0);
                                state_reg <= ST_TRD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_CHK: begin
                    state_reg <= ST_PUSH;
                    if (rd_reg.generation == handle_reg[31:16]) begin
                        res_reg.owner <= rd_reg.owner;
                        if (mode_reg == MODE_CANCEL) begin
                            res_reg.code <= EV_CANCELLED;
                            used_reg[handle_reg[IW-1:0]] <= 1'b0;
                            changed_reg <= 1'b1;
                            gen_reg <= gen_reg + 1'b1;
                        end else begin
                            res_reg.code <= EV_INFO;
                            res_reg.remaining <= rd_reg.remaining;
                            res_reg.delay <= rd_reg.delay;
                            res_reg.rep <= rd_reg.repeat_flag;
                        end
                    end
                end
                ST_KRD: state_reg <= ST_KEV;
                ST_KEV: begin
                    if (cur_used && rd_reg.owner == owner_reg) begin
                        used_reg[cnt_reg] <= 1'b0;
                        changed_reg <= 1'b1;
                        if (kcount_reg != 5'd31) begin
                            kcount_reg <= kcount_reg + 1'b1;
                            res_reg.killed <= kcount_reg + 1'b1;
                        end
                    end
                    if (cnt_reg == IW'(TIMER_SLOTS - 1)) begin
                        state_reg <= ST_PUSH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= ST_KRD;
                    end
                end
                ST_TRD: state_reg <= ST_TEV;
                ST_TEV: begin
                    if (cur_used && fire) begin
                        res_reg.code <= rd_reg.repeat_flag ? EV_FIRED_REP : EV_FIRED_DIE;
                        res_reg.handle <= {rd_reg.generation, 16'(cnt_reg)};
                        res_reg.owner <= rd_reg.owner;
                        res_reg.elapsed <= elapsed;
                        res_reg.last <= 1'b0;
                        ret_reg <= need_div ? ST_TDIV : ST_TNEXT;
                        state_reg <= ST_PUSH;
                        if (!rd_reg.repeat_flag) begin
                            used_reg[cnt_reg] <= 1'b0;
                            changed_reg <= 1'b1;
                        end
                    end else begin
                        state_reg <= ST_TNEXT;
                    end
                end
                ST_TDIV: begin
                    if (div_done) begin
                        state_reg <= ST_TNEXT;
                    end
                end
                ST_TNEXT: begin
                    if (cnt_reg == IW'(TIMER_SLOTS - 1)) begin
                        if (changed_reg) begin
                            gen_reg <= gen_reg + 1'b1;
                        end
                        changed_reg <= 1'b0;
                        res_reg <= blank_result(EV_TICK_DONE, '1, '0);
                        ret_reg <= ST_IDLE;
                        state_reg <= ST_PUSH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= ST_TRD;
                    end
                end
                ST_PUSH: begin
                    if (!m_valid_reg || m_tready) begin
                        out_reg <= res_reg;
                        state_reg <= ret_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.code;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {3'b000, out_reg.rep, out_reg.delay, out_reg.remaining,
                       out_reg.killed, out_reg.elapsed, out_reg.owner, out_reg.handle};

    // generation only steps by one
    a_gen_step: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_reg != $past(gen_reg) |-> gen_reg == $past(gen_reg) + 1'b1)
        else $error("generation counter jumped");

    // slots are only taken by an add
    a_used_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) > $countones($past(used_reg)) |->
        $past(s_acc) && $past(s_tuser) == MODE_ADD)
        else $error("slot became used outside an add");

    // a tick done result always closes the command
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_TICK_DONE |-> m_tlast)
        else $error("tick done without last");

    // the remainder unit only starts inside a tick
    a_div_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> mode_reg == MODE_TICK)
        else $error("remainder started outside tick");
endmodule
`default_nettype wire
